/* sv/tpcp_pkg.sv */
// ---------------------------------------------------------------------------
// tpcp_pkg
// shared widths, register indexes, command struct and helpers for the
// two-view cheirality and parallax check
// ---------------------------------------------------------------------------
package tpcp_pkg;

    localparam int MAX_POINTS_DEF = 4096;
    localparam int CNT_W          = 13;
    localparam int ACC_W          = 98;
    localparam int NB_W           = 6;

    localparam logic [2:0] REG_ROT0  = 3'd0;
    localparam logic [2:0] REG_ROT1  = 3'd1;
    localparam logic [2:0] REG_ROT2  = 3'd2;
    localparam logic [2:0] REG_TX    = 3'd3;
    localparam logic [2:0] REG_TY    = 3'd4;
    localparam logic [2:0] REG_TZ    = 3'd5;
    localparam logic [2:0] REG_COS   = 3'd6;

    typedef struct packed {
        logic              start;
        logic              load;
        logic              neg;
        logic [NB_W-1:0]   nbits;
        logic [ACC_W-1:0]  init;
        logic [63:0]       m;
        logic [31:0]       q;
    } mac_cmd_t;

    function automatic logic [15:0] abs16(input logic [15:0] v);
        logic [15:0] n;
        n = 16'(~v + 16'd1);
        return v[15] ? n : v;
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] v);
        logic [31:0] n;
        n = 32'(~v + 32'd1);
        return v[31] ? n : v;
    endfunction

endpackage

/* sv/triangulated_point_cheirality_parallax_core.sv */
// ---------------------------------------------------------------------------
// triangulated_point_cheirality_parallax_core
// cheirality and parallax test of triangulated points, with per-set counts
// ---------------------------------------------------------------------------
// channel  dir  handshake                  payload
// s_axis   in   s_axis_tvalid/tready       tdata point x,y,z; tuser inlier; tlast final
// m_axis   out  m_axis_tvalid/tready       tdata good_count; tuser flags; tlast set_done
// cfg      in   cfg_valid/cfg_ready        cfg_addr register index, cfg_data value
//
// one point at a time through a single bit-serial multiply-accumulate unit;
// each point takes the 25 serial products (one multiplier bit per cycle)
// and a normalizing shift of one bit per cycle
// reset clears control and counts and sets the configuration registers to their defaults
// a finished result waits in the output register; the next point is taken
// while it waits, and a stalled output holds the last step only
// ---------------------------------------------------------------------------
module triangulated_point_cheirality_parallax_core
    import tpcp_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // point_x, point_y, point_z
    input  logic        s_axis_tuser,   // inlier
    input  logic        s_axis_tlast,   // final_point
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // good_count, zero fill
    output logic [2:0]  m_axis_tuser,   // depth_good, all_good, early_exit
    output logic        m_axis_tlast,   // set_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [47:0] cfg_data
);

    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'((MAX_POINTS < 8191) ? MAX_POINTS : 8191);

    typedef enum logic [2:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_RED, ST_FIN} state_t;

    typedef enum logic [4:0] {
        S_ZC0, S_ZC1, S_ZC2,
        S_B00, S_B01, S_B02,
        S_B10, S_B11, S_B12,
        S_B20, S_B21, S_B22,
        S_D0, S_D1, S_D2,
        S_NA0, S_NA1, S_NA2,
        S_NB0, S_NB1, S_NB2,
        S_DSQ, S_LSQ, S_NN, S_RHS
    } step_t;

    state_t state_reg;
    step_t  step_reg;

    logic [47:0] rot_reg [3];
    logic [31:0] tr_reg [3];
    logic [15:0] cos_reg;

    logic [31:0] x_reg [3];
    logic        inl_reg;
    logic        fin_reg;

    logic [31:0] amag_reg [3];
    logic        asgn_reg [3];
    logic [48:0] bmag_reg [3];
    logic        bsgn_reg [3];
    logic        zc_pos_reg;
    logic [32:0] d_reg;
    logic [31:0] na_reg;
    logic [31:0] nb_reg;
    logic [93:0] lhs_reg;
    logic [31:0] l2_reg;
    logic [63:0] nn_reg;
    logic        cmp_reg;

    logic [CNT_W-1:0] seen_reg, depth_reg, full_reg;

    logic        out_valid_reg;
    logic [15:0] out_data_reg;
    logic [2:0]  out_user_reg;
    logic        out_last_reg;

    mac_cmd_t         cmd;
    logic             mac_busy;
    logic [ACC_W-1:0] acc;

    logic [15:0] rc [3][3];
    logic [15:0] sel_coef;
    logic [31:0] sel_val;
    logic        sel_lin;
    logic [ACC_W-1:0] acc_neg;
    logic [32:0] d_neg;
    logic [31:0] dmag;
    logic        a_big, b_big, a_nz, b_nz;
    logic        dg, ag;
    logic [CNT_W-1:0] seen_next, depth_next, full_next;
    logic        early;

    tpcp_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .busy  (mac_busy),
        .acc   (acc)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                rc[i][j] = rot_reg[i][16*j +: 16];
            end
        end
    end

    assign acc_neg = ACC_W'(~acc + ACC_W'(1));
    assign d_neg   = 33'(~d_reg + 33'd1);
    assign dmag    = d_reg[32] ? d_neg[31:0] : d_reg[31:0];

    // operand selection for each serial product
    always_comb
    begin
        cmd       = '0;
        cmd.start = (state_reg == ST_ISSUE);
        sel_coef  = '0;
        sel_val   = '0;
        sel_lin   = 1'b1;
        case (step_reg)
            S_ZC0:
            begin
                cmd.load = 1'b1;
                cmd.init = ACC_W'({{(ACC_W-46){tr_reg[2][31]}}, tr_reg[2], 14'd0});
                sel_coef = rc[2][0];
                sel_val  = x_reg[0];
            end
            S_ZC1:   begin sel_coef = rc[2][1]; sel_val = x_reg[1]; end
            S_ZC2:   begin sel_coef = rc[2][2]; sel_val = x_reg[2]; end
            S_B00:
            begin
                cmd.load = 1'b1;
                cmd.init = ACC_W'({{(ACC_W-46){x_reg[0][31]}}, x_reg[0], 14'd0});
                sel_coef = rc[0][0];
                sel_val  = tr_reg[0];
            end
            S_B01:   begin sel_coef = rc[1][0]; sel_val = tr_reg[1]; end
            S_B02:   begin sel_coef = rc[2][0]; sel_val = tr_reg[2]; end
            S_B10:
            begin
                cmd.load = 1'b1;
                cmd.init = ACC_W'({{(ACC_W-46){x_reg[1][31]}}, x_reg[1], 14'd0});
                sel_coef = rc[0][1];
                sel_val  = tr_reg[0];
            end
            S_B11:   begin sel_coef = rc[1][1]; sel_val = tr_reg[1]; end
            S_B12:   begin sel_coef = rc[2][1]; sel_val = tr_reg[2]; end
            S_B20:
            begin
                cmd.load = 1'b1;
                cmd.init = ACC_W'({{(ACC_W-46){x_reg[2][31]}}, x_reg[2], 14'd0});
                sel_coef = rc[0][2];
                sel_val  = tr_reg[0];
            end
            S_B21:   begin sel_coef = rc[1][2]; sel_val = tr_reg[1]; end
            S_B22:   begin sel_coef = rc[2][2]; sel_val = tr_reg[2]; end
            S_D0, S_D1, S_D2:
            begin
                sel_lin   = 1'b0;
                cmd.load  = (step_reg == S_D0);
                cmd.nbits = NB_W'(15);
                for (int k = 0; k < 3; k++)
                begin
                    if (step_reg == step_t'(int'(S_D0) + k))
                    begin
                        cmd.m   = 64'(amag_reg[k][14:0]);
                        cmd.q   = 32'(bmag_reg[k][14:0]);
                        cmd.neg = asgn_reg[k] ^ bsgn_reg[k];
                    end
                end
            end
            S_NA0, S_NA1, S_NA2:
            begin
                sel_lin   = 1'b0;
                cmd.load  = (step_reg == S_NA0);
                cmd.nbits = NB_W'(15);
                for (int k = 0; k < 3; k++)
                begin
                    if (step_reg == step_t'(int'(S_NA0) + k))
                    begin
                        cmd.m = 64'(amag_reg[k][14:0]);
                        cmd.q = 32'(amag_reg[k][14:0]);
                    end
                end
            end
            S_NB0, S_NB1, S_NB2:
            begin
                sel_lin   = 1'b0;
                cmd.load  = (step_reg == S_NB0);
                cmd.nbits = NB_W'(15);
                for (int k = 0; k < 3; k++)
                begin
                    if (step_reg == step_t'(int'(S_NB0) + k))
                    begin
                        cmd.m = 64'(bmag_reg[k][14:0]);
                        cmd.q = 32'(bmag_reg[k][14:0]);
                    end
                end
            end
            S_DSQ:
            begin
                sel_lin   = 1'b0;
                cmd.load  = 1'b1;
                cmd.nbits = NB_W'(32);
                cmd.m     = 64'(dmag);
                cmd.q     = dmag;
            end
            S_LSQ:
            begin
                sel_lin   = 1'b0;
                cmd.load  = 1'b1;
                cmd.nbits = NB_W'(16);
                cmd.m     = 64'(cos_reg);
                cmd.q     = 32'(cos_reg);
            end
            S_NN:
            begin
                sel_lin   = 1'b0;
                cmd.load  = 1'b1;
                cmd.nbits = NB_W'(32);
                cmd.m     = 64'(na_reg);
                cmd.q     = nb_reg;
            end
            S_RHS:
            begin
                sel_lin   = 1'b0;
                cmd.load  = 1'b1;
                cmd.nbits = NB_W'(32);
                cmd.m     = nn_reg;
                cmd.q     = l2_reg;
            end
            default:
            begin
                sel_lin = 1'b0;
            end
        endcase
        if (sel_lin)
        begin
            cmd.nbits = NB_W'(16);
            cmd.m     = 64'(abs32(sel_val));
            cmd.q     = 32'(abs16(sel_coef));
            cmd.neg   = sel_coef[15] ^ sel_val[31];
        end
    end

    always_comb
    begin
        a_big = 1'b0;
        b_big = 1'b0;
        a_nz  = 1'b0;
        b_nz  = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            a_big = a_big | (|amag_reg[k][31:15]);
            b_big = b_big | (|bmag_reg[k][48:15]);
            a_nz  = a_nz | (|amag_reg[k]);
            b_nz  = b_nz | (|bmag_reg[k]);
        end
    end

    // inlier, x2 > 0 and camera z > 0
    assign dg = inl_reg & ~x_reg[2][31] & (|x_reg[2]) & zc_pos_reg;
    assign ag = dg & a_nz & b_nz & (d_reg[32] | cmp_reg);

    assign seen_next  = (seen_reg < CNT_CAP) ? CNT_W'(seen_reg + 1'b1) : seen_reg;
    assign depth_next = (dg && depth_reg < CNT_CAP) ? CNT_W'(depth_reg + 1'b1) : depth_reg;
    assign full_next  = (ag && full_reg < CNT_CAP) ? CNT_W'(full_reg + 1'b1) : full_reg;
    assign early      = (16'(depth_next) * 16'd5) < (16'(seen_next) * 16'd4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= S_ZC0;
            rot_reg[0]    <= 48'd16384;
            rot_reg[1]    <= 48'd16384 << 16;
            rot_reg[2]    <= 48'd16384 << 32;
            tr_reg[0]     <= '0;
            tr_reg[1]     <= '0;
            tr_reg[2]     <= '0;
            cos_reg       <= 16'd32763;
            seen_reg      <= '0;
            depth_reg     <= '0;
            full_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_addr)
                    REG_ROT0: rot_reg[0] <= cfg_data;
                    REG_ROT1: rot_reg[1] <= cfg_data;
                    REG_ROT2: rot_reg[2] <= cfg_data;
                    REG_TX:   tr_reg[0]  <= cfg_data[31:0];
                    REG_TY:   tr_reg[1]  <= cfg_data[31:0];
                    REG_TZ:   tr_reg[2]  <= cfg_data[31:0];
                    REG_COS:  cos_reg    <= cfg_data[15:0];
                    default:  ;
                endcase
            end

            if (state_reg == ST_FIN && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        step_reg  <= S_ZC0;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (!mac_busy)
                    begin
                        if (step_reg == S_B22)
                        begin
                            state_reg <= ST_RED;
                        end
                        else if (step_reg == S_RHS)
                        begin
                            state_reg <= ST_FIN;
                        end
                        else
                        begin
                            step_reg  <= step_t'(step_reg + 5'd1);
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_RED:
                begin
                    if (!a_big && !b_big)
                    begin
                        step_reg  <= S_D0;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_FIN:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        state_reg <= ST_IDLE;
                        if (fin_reg)
                        begin
                            seen_reg  <= '0;
                            depth_reg <= '0;
                            full_reg  <= '0;
                        end
                        else
                        begin
                            seen_reg  <= seen_next;
                            depth_reg <= depth_next;
                            full_reg  <= full_next;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_axis_tvalid)
        begin
            for (int k = 0; k < 3; k++)
            begin
                x_reg[k]    <= s_axis_tdata[32*k +: 32];
                amag_reg[k] <= abs32(s_axis_tdata[32*k +: 32]);
                asgn_reg[k] <= s_axis_tdata[32*k + 31];
            end
            inl_reg <= s_axis_tuser;
            fin_reg <= s_axis_tlast;
        end

        if (state_reg == ST_WAIT && !mac_busy)
        begin
            case (step_reg)
                S_ZC2: zc_pos_reg <= ~acc[ACC_W-1] & (|acc);
                S_B02:
                begin
                    bmag_reg[0] <= acc[ACC_W-1] ? acc_neg[48:0] : acc[48:0];
                    bsgn_reg[0] <= acc[ACC_W-1];
                end
                S_B12:
                begin
                    bmag_reg[1] <= acc[ACC_W-1] ? acc_neg[48:0] : acc[48:0];
                    bsgn_reg[1] <= acc[ACC_W-1];
                end
                S_B22:
                begin
                    bmag_reg[2] <= acc[ACC_W-1] ? acc_neg[48:0] : acc[48:0];
                    bsgn_reg[2] <= acc[ACC_W-1];
                end
                S_D2:  d_reg   <= acc[32:0];
                S_NA2: na_reg  <= acc[31:0];
                S_NB2: nb_reg  <= acc[31:0];
                S_DSQ: lhs_reg <= {acc[63:0], 30'd0};
                S_LSQ: l2_reg  <= acc[31:0];
                S_NN:  nn_reg  <= acc[63:0];
                S_RHS: cmp_reg <= (96'(lhs_reg) < acc[95:0]);
                default: ;
            endcase
        end

        // one-bit normalizing shift per cycle, each ray on its own
        if (state_reg == ST_RED)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (a_big)
                begin
                    amag_reg[k] <= {1'b0, amag_reg[k][31:1]};
                end
                if (b_big)
                begin
                    bmag_reg[k] <= {1'b0, bmag_reg[k][48:1]};
                end
            end
        end

        if (state_reg == ST_FIN && (!out_valid_reg || m_axis_tready))
        begin
            out_user_reg <= {fin_reg & early, ag, dg};
            out_last_reg <= fin_reg;
            out_data_reg <= fin_reg ? 16'(early ? depth_next : full_next) : 16'd0;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

/* sv/tpcp_mac.sv */
// ---------------------------------------------------------------------------
// tpcp_mac
// bit-serial multiply-accumulate: acc +/- m*q, one multiplier bit per cycle
// ---------------------------------------------------------------------------
module tpcp_mac
    import tpcp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  mac_cmd_t         cmd,
    output logic             busy,
    output logic [ACC_W-1:0] acc
);

    logic             busy_reg;
    logic [NB_W-1:0]  cnt_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] m_reg;
    logic [31:0]      q_reg;
    logic             neg_reg;
    logic [ACC_W-1:0] acc_next;

    always_comb
    begin
        acc_next = acc_reg;
        if (q_reg[0])
        begin
            acc_next = neg_reg ? ACC_W'(acc_reg - m_reg) : ACC_W'(acc_reg + m_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= cmd.nbits;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - NB_W'(1);
            if (cnt_reg == NB_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            if (cmd.load)
            begin
                acc_reg <= cmd.init;
            end
            m_reg   <= ACC_W'(cmd.m);
            q_reg   <= cmd.q;
            neg_reg <= cmd.neg;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            m_reg   <= {m_reg[ACC_W-2:0], 1'b0};
            q_reg   <= {1'b0, q_reg[31:1]};
        end
    end

    assign busy = busy_reg;
    assign acc  = acc_reg;

endmodule

/* sv/tpcp_checker.sv */
// ---------------------------------------------------------------------------
// tpcp_checker
// port-level checks on the result stream of the cheirality core
// ---------------------------------------------------------------------------
module tpcp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // stalled item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result item changed while stalled");

    // all_good implies depth_good
    a_good: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
        else $error("all_good without depth_good");

    // count and early flag only on the last item of a set
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata == 16'd0 && !m_axis_tuser[2])
        else $error("report fields set on a non-final item");

    // count never exceeds the 13-bit range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:13] == 3'd0)
        else $error("good_count out of range");

endmodule

bind triangulated_point_cheirality_parallax_core tpcp_checker u_tpcp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
